FILE: rtl/core/jet_pkg.sv
// Shared types, widths, register codes and helper functions of the Julia escape-time core.
package jet_pkg;

  localparam int GRID_SIZE = 256;

  localparam int FRAC    = 24;
  localparam int IDX_W   = 8;
  localparam int CR_W    = 28;
  localparam int ORG_W   = 29;
  localparam int STEP_W  = 25;
  localparam int LIM_W   = 13;
  localparam int CNT_W   = 8;
  localparam int CFG_W   = 29;
  localparam int CFG_A_W = 3;
  localparam int Z_W     = 48;
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int OFF_W   = IDX_W + STEP_W;

  localparam logic signed [CR_W-1:0]  C_REAL_RST   = CR_W'(5536481);
  localparam logic signed [CR_W-1:0]  C_IMAG_RST   = CR_W'(6710886);
  localparam logic signed [ORG_W-1:0] ORIGIN_RST   = ORG_W'(-25165824);
  localparam logic [STEP_W-1:0]       STEP_RST     = STEP_W'(252923);
  localparam logic [LIM_W-1:0]        LIMIT_RST    = LIM_W'(100);
  localparam logic [CNT_W-1:0]        MAX_ITER_RST = CNT_W'(15);

  typedef enum logic [CFG_A_W-1:0] {
    CFG_C_REAL    = 3'd0,
    CFG_C_IMAG    = 3'd1,
    CFG_X_ORIGIN  = 3'd2,
    CFG_Y_ORIGIN  = 3'd3,
    CFG_X_STEP    = 3'd4,
    CFG_Y_STEP    = 3'd5,
    CFG_ESC_LIMIT = 3'd6,
    CFG_MAX_ITER  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic init;
    logic mul;
    logic advance;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic escaped;
    logic last;
  } status_t;

  function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] v);
    if (int'(v) >= GRID_SIZE) begin
      return IDX_W'(GRID_SIZE - 1);
    end
    return v;
  endfunction

  // A coordinate is out of range for the squaring step when its magnitude is 2^31 or more.
  function automatic logic is_big(input logic signed [Z_W-1:0] v);
    logic [Z_W-MUL_W:0] hi;
    hi = v[Z_W-1:MUL_W-1];
    return !((hi == '0) || ((hi == '1) && (v[MUL_W-2:0] != '0)));
  endfunction

endpackage

FILE: rtl/core/jet_ctrl.sv
// Controller state machine that sequences mapping, squaring and update steps.
module jet_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  jet_pkg::status_t status_i,
  output jet_pkg::cmd_t    cmd_o
);

  jet_pkg::state_e state_q, state_d;
  logic            finish;

  assign finish = status_i.escaped || status_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jet_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jet_pkg::ST_IDLE: begin
        if (start) begin
          state_d = jet_pkg::ST_MUL;
        end
      end
      jet_pkg::ST_MUL: begin
        state_d = jet_pkg::ST_UPD;
      end
      jet_pkg::ST_UPD: begin
        state_d = finish ? jet_pkg::ST_IDLE : jet_pkg::ST_MUL;
      end
      default: begin
        state_d = jet_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      jet_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.init = start;
      end
      jet_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
      end
      jet_pkg::ST_UPD: begin
        cmd_o.finish  = finish;
        cmd_o.advance = !finish;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/core/jet_datapath.sv
// Datapath with configuration registers, coordinate mapping, squaring and escape test.
module jet_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [jet_pkg::CFG_A_W-1:0] cfg_idx_i,
  input  logic [jet_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic [jet_pkg::IDX_W-1:0]   pixel_col_i,
  input  logic [jet_pkg::IDX_W-1:0]   pixel_row_i,
  input  jet_pkg::cmd_t               cmd_i,
  output jet_pkg::status_t            status_o,
  output logic                        done_o,
  output logic [jet_pkg::CNT_W-1:0]   iteration_count_o
);

  logic signed [jet_pkg::CR_W-1:0]   c_real_q, c_imag_q;
  logic signed [jet_pkg::ORG_W-1:0]  x_origin_q, y_origin_q;
  logic [jet_pkg::STEP_W-1:0]        x_step_q, y_step_q;
  logic [jet_pkg::LIM_W-1:0]         esc_limit_q;
  logic [jet_pkg::CNT_W-1:0]         max_iter_q;

  logic [jet_pkg::OFF_W-1:0]         col_off, row_off;
  logic signed [jet_pkg::Z_W-1:0]    x_init, y_init, x_next, y_next;
  logic signed [jet_pkg::Z_W-1:0]    x_q, y_q;
  logic signed [jet_pkg::MUL_W-1:0]  x_op, y_op;
  logic signed [jet_pkg::PROD_W-1:0] xx_c, yy_c, xy_c;
  logic signed [jet_pkg::PROD_W-1:0] xx_q, yy_q, xy_q;
  logic                              huge_q;
  logic [jet_pkg::CNT_W:0]           k_q, k_max;
  logic [jet_pkg::PROD_W-1:0]        mag_sum, limit;
  logic                              escaped;
  logic                              done_q;
  logic [jet_pkg::CNT_W-1:0]         count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_real_q    <= jet_pkg::C_REAL_RST;
      c_imag_q    <= jet_pkg::C_IMAG_RST;
      x_origin_q  <= jet_pkg::ORIGIN_RST;
      y_origin_q  <= jet_pkg::ORIGIN_RST;
      x_step_q    <= jet_pkg::STEP_RST;
      y_step_q    <= jet_pkg::STEP_RST;
      esc_limit_q <= jet_pkg::LIMIT_RST;
      max_iter_q  <= jet_pkg::MAX_ITER_RST;
    end else if (cfg_we_i) begin
      unique case (jet_pkg::cfg_idx_e'(cfg_idx_i))
        jet_pkg::CFG_C_REAL:    c_real_q    <= cfg_wdata_i[jet_pkg::CR_W-1:0];
        jet_pkg::CFG_C_IMAG:    c_imag_q    <= cfg_wdata_i[jet_pkg::CR_W-1:0];
        jet_pkg::CFG_X_ORIGIN:  x_origin_q  <= cfg_wdata_i[jet_pkg::ORG_W-1:0];
        jet_pkg::CFG_Y_ORIGIN:  y_origin_q  <= cfg_wdata_i[jet_pkg::ORG_W-1:0];
        jet_pkg::CFG_X_STEP:    x_step_q    <= cfg_wdata_i[jet_pkg::STEP_W-1:0];
        jet_pkg::CFG_Y_STEP:    y_step_q    <= cfg_wdata_i[jet_pkg::STEP_W-1:0];
        jet_pkg::CFG_ESC_LIMIT: esc_limit_q <= cfg_wdata_i[jet_pkg::LIM_W-1:0];
        jet_pkg::CFG_MAX_ITER:  max_iter_q  <= cfg_wdata_i[jet_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign col_off = jet_pkg::clamp_idx(pixel_col_i) * x_step_q;
  assign row_off = jet_pkg::clamp_idx(pixel_row_i) * y_step_q;
  assign x_init  = jet_pkg::Z_W'(x_origin_q) + jet_pkg::Z_W'(col_off);
  assign y_init  = jet_pkg::Z_W'(y_origin_q) + jet_pkg::Z_W'(row_off);

  assign x_op = x_q[jet_pkg::MUL_W-1:0];
  assign y_op = y_q[jet_pkg::MUL_W-1:0];
  assign xx_c = x_op * x_op;
  assign yy_c = y_op * y_op;
  assign xy_c = x_op * y_op;

  // The floor of 2xy in Q48 taken to Q24 equals xy shifted right by one bit less.
  assign x_next = jet_pkg::Z_W'((xx_q - yy_q) >>> jet_pkg::FRAC) + jet_pkg::Z_W'(c_real_q);
  assign y_next = jet_pkg::Z_W'(xy_q >>> (jet_pkg::FRAC - 1)) + jet_pkg::Z_W'(c_imag_q);

  assign mag_sum = xx_q + yy_q;
  assign limit   = jet_pkg::PROD_W'(esc_limit_q) << (2 * jet_pkg::FRAC);
  assign escaped = huge_q || (mag_sum > limit);

  // A zero iteration limit runs the full range of the eight-bit counter.
  assign k_max = (max_iter_q == '0) ? (jet_pkg::CNT_W + 1)'(1 << jet_pkg::CNT_W)
                                    : {1'b0, max_iter_q};

  assign status_o.escaped = escaped;
  assign status_o.last    = (k_q == k_max);

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      x_q <= x_init;
      y_q <= y_init;
      k_q <= '0;
    end else if (cmd_i.advance) begin
      x_q <= x_next;
      y_q <= y_next;
    end
    if (cmd_i.mul) begin
      xx_q   <= xx_c;
      yy_q   <= yy_c;
      xy_q   <= xy_c;
      huge_q <= jet_pkg::is_big(x_q) || jet_pkg::is_big(y_q);
      k_q    <= k_q + 1'b1;
    end
    if (cmd_i.finish) begin
      count_q <= escaped ? k_q[jet_pkg::CNT_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  assign done_o            = done_q;
  assign iteration_count_o = count_q;

endmodule

FILE: rtl/core/julia_escape_time_core.sv
// Top level of the Julia escape-time core: controller and datapath.
//
//   Channel   Signals                                     Direction  Flow control
//   request   start, busy, pixel_col_i, pixel_row_i       in         taken when start && !busy
//   result    done_o, iteration_count_o                   out        one-cycle strobe, no stall
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i            in         written when cfg_we_i
//
// A request of n iterations (1 to max_iterations, or 256 when it is zero) loads its start point
// at the accepting edge, then runs a loop of a registered multiply stage and the escape test and
// update stage once per iteration; the result is registered before it reaches the ports.
// A new request is taken in the cycle in which the previous result is on the ports.
// Reset clears the controller, the strobe and loads the default configuration.
// The result strobe cannot be held off; each result is shown for one cycle.
module julia_escape_time_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [jet_pkg::IDX_W-1:0]   pixel_col_i,
  input  logic [jet_pkg::IDX_W-1:0]   pixel_row_i,
  output logic                        done_o,
  output logic [jet_pkg::CNT_W-1:0]   iteration_count_o,
  input  logic                        cfg_we_i,
  input  logic [jet_pkg::CFG_A_W-1:0] cfg_idx_i,
  input  logic [jet_pkg::CFG_W-1:0]   cfg_wdata_i
);

  jet_pkg::cmd_t    cmd;
  jet_pkg::status_t status;

  jet_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  jet_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .pixel_col_i       (pixel_col_i),
    .pixel_row_i       (pixel_row_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .done_o            (done_o),
    .iteration_count_o (iteration_count_o)
  );

endmodule

FILE: rtl/core/jet_checker.sv
// Port-level timing checks of the Julia escape-time core and their binding to it.
module jet_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted request");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

endmodule

bind julia_escape_time_core jet_checker u_jet_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);

FILE: bench/julia_escape_time_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the Julia escape-time core: directed and random pixel requests.
module julia_escape_time_core_test;

  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     TAIL_CYCLES    = 32;
  localparam int     RANDOM_PHASES  = 12;
  localparam longint COORD_LIMIT    = longint'(1) << 31;

  typedef enum logic {
    ROW_CFG,
    ROW_PIX
  } row_kind_e;

  typedef enum logic [1:0] {
    MODE_CLASSIC,
    MODE_DEEP,
    MODE_WIDE,
    MODE_ZERO_CAP
  } view_mode_e;

  typedef struct packed {
    row_kind_e                 kind;
    jet_pkg::cfg_idx_e         idx;
    longint                    value;
    logic [jet_pkg::IDX_W-1:0] col;
    logic [jet_pkg::IDX_W-1:0] row;
    logic                      fixed;
    logic [jet_pkg::CNT_W-1:0] count;
  } plan_row_t;

  typedef struct packed {
    logic [jet_pkg::IDX_W-1:0] col;
    logic [jet_pkg::IDX_W-1:0] row;
    logic [jet_pkg::CNT_W-1:0] count;
  } pixel_expect_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        start       = 1'b0;
  logic                        busy;
  logic [jet_pkg::IDX_W-1:0]   pixel_col_i = '0;
  logic [jet_pkg::IDX_W-1:0]   pixel_row_i = '0;
  logic                        done_o;
  logic [jet_pkg::CNT_W-1:0]   iteration_count_o;
  logic                        cfg_we_i    = 1'b0;
  logic [jet_pkg::CFG_A_W-1:0] cfg_idx_i   = '0;
  logic [jet_pkg::CFG_W-1:0]   cfg_wdata_i = '0;

  logic signed [jet_pkg::CR_W-1:0]  c_re;
  logic signed [jet_pkg::CR_W-1:0]  c_im;
  logic signed [jet_pkg::ORG_W-1:0] x_org;
  logic signed [jet_pkg::ORG_W-1:0] y_org;
  logic [jet_pkg::STEP_W-1:0]       x_inc;
  logic [jet_pkg::STEP_W-1:0]       y_inc;
  logic [jet_pkg::LIM_W-1:0]        esc_lim;
  logic [jet_pkg::CNT_W-1:0]        iter_cap;

  pixel_expect_t counts_due[$];
  pixel_expect_t due;
  plan_row_t     plan[$];
  view_mode_e    mode;
  int            gap_pct;
  int            requests_sent;
  int            results_seen;
  int            writes_done;
  int            errors;
  int            quiet_cycles;
  int            n_items;

  julia_escape_time_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .pixel_col_i       (pixel_col_i),
    .pixel_row_i       (pixel_row_i),
    .done_o            (done_o),
    .iteration_count_o (iteration_count_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [jet_pkg::CNT_W-1:0] escape_count(
      input logic [jet_pkg::IDX_W-1:0] col, input logic [jet_pkg::IDX_W-1:0] row);
    int     cx;
    int     cy;
    int     k;
    int     k_end;
    longint x;
    longint y;
    longint nx;
    longint ax;
    longint ay;
    longint bound;
    cx = (int'(col) >= jet_pkg::GRID_SIZE) ? jet_pkg::GRID_SIZE - 1 : int'(col);
    cy = (int'(row) >= jet_pkg::GRID_SIZE) ? jet_pkg::GRID_SIZE - 1 : int'(row);
    x = longint'(x_org) + longint'(cx) * longint'(x_inc);
    y = longint'(y_org) + longint'(cy) * longint'(y_inc);
    bound = longint'(esc_lim) << (2 * jet_pkg::FRAC);
    k_end = (iter_cap == '0) ? 256 : int'(iter_cap);
    for (k = 1; k <= k_end; k++) begin
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      if (ax >= COORD_LIMIT || ay >= COORD_LIMIT) begin
        return jet_pkg::CNT_W'(k);
      end
      if (ax * ax + ay * ay > bound) begin
        return jet_pkg::CNT_W'(k);
      end
      nx = ((x * x - y * y) >>> jet_pkg::FRAC) + longint'(c_re);
      y  = ((2 * x * y) >>> jet_pkg::FRAC) + longint'(c_im);
      x  = nx;
    end
    return '0;
  endfunction

  function automatic longint span(input longint lo, input longint hi);
    return lo + longint'($urandom_range(32'(hi - lo)));
  endfunction

  function automatic plan_row_t cfg_row(input jet_pkg::cfg_idx_e idx, input longint value);
    plan_row_t r;
    r       = '0;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.value = value;
    return r;
  endfunction

  function automatic plan_row_t pix_row(input int col, input int row);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_PIX;
    r.col  = jet_pkg::IDX_W'(col);
    r.row  = jet_pkg::IDX_W'(row);
    return r;
  endfunction

  function automatic plan_row_t pix_fixed(input int col, input int row, input int count);
    plan_row_t r;
    r       = pix_row(col, row);
    r.fixed = 1'b1;
    r.count = jet_pkg::CNT_W'(count);
    return r;
  endfunction

  task automatic write_reg(input jet_pkg::cfg_idx_e idx, input longint value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= jet_pkg::CFG_W'(value);
    case (idx)
      jet_pkg::CFG_C_REAL:    c_re     = jet_pkg::CR_W'(value);
      jet_pkg::CFG_C_IMAG:    c_im     = jet_pkg::CR_W'(value);
      jet_pkg::CFG_X_ORIGIN:  x_org    = jet_pkg::ORG_W'(value);
      jet_pkg::CFG_Y_ORIGIN:  y_org    = jet_pkg::ORG_W'(value);
      jet_pkg::CFG_X_STEP:    x_inc    = jet_pkg::STEP_W'(value);
      jet_pkg::CFG_Y_STEP:    y_inc    = jet_pkg::STEP_W'(value);
      jet_pkg::CFG_ESC_LIMIT: esc_lim  = jet_pkg::LIM_W'(value);
      jet_pkg::CFG_MAX_ITER:  iter_cap = jet_pkg::CNT_W'(value);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    writes_done++;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [jet_pkg::IDX_W-1:0] col,
                            input logic [jet_pkg::IDX_W-1:0] row,
                            input logic fixed, input logic [jet_pkg::CNT_W-1:0] count);
    pixel_expect_t e;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    start       <= 1'b1;
    pixel_col_i <= col;
    pixel_row_i <= row;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    e.col   = col;
    e.row   = row;
    e.count = fixed ? count : escape_count(col, row);
    counts_due.push_back(e);
    requests_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (counts_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic pick_settings(input view_mode_e m);
    longint sx;
    longint sy;
    if (m == MODE_WIDE) begin
      write_reg(jet_pkg::CFG_C_REAL,    span(-(1 << 26), 1 << 26));
      write_reg(jet_pkg::CFG_C_IMAG,    span(-(1 << 26), 1 << 26));
      write_reg(jet_pkg::CFG_X_ORIGIN,  span(-(1 << 27), 1 << 27));
      write_reg(jet_pkg::CFG_Y_ORIGIN,  span(-(1 << 27), 1 << 27));
      write_reg(jet_pkg::CFG_X_STEP,    span(0, 1 << 24));
      write_reg(jet_pkg::CFG_Y_STEP,    span(0, 1 << 24));
      write_reg(jet_pkg::CFG_ESC_LIMIT, span(0, 4096));
      write_reg(jet_pkg::CFG_MAX_ITER,  span(1, 255));
    end else begin
      sx = span(1 << 16, 1 << 18);
      sy = span(1 << 16, 1 << 18);
      write_reg(jet_pkg::CFG_C_REAL,    span(-(1 << 24), 1 << 23));
      write_reg(jet_pkg::CFG_C_IMAG,    span(-(1 << 24), 1 << 24));
      write_reg(jet_pkg::CFG_X_ORIGIN,  span(-(1 << 23), 1 << 23) - sx * 128);
      write_reg(jet_pkg::CFG_Y_ORIGIN,  span(-(1 << 23), 1 << 23) - sy * 128);
      write_reg(jet_pkg::CFG_X_STEP,    sx);
      write_reg(jet_pkg::CFG_Y_STEP,    sy);
      write_reg(jet_pkg::CFG_ESC_LIMIT, span(4, 16));
      write_reg(jet_pkg::CFG_MAX_ITER,
                (m == MODE_DEEP) ? 255 : (m == MODE_ZERO_CAP) ? 0 : span(8, 48));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      results_seen++;
      if (counts_due.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, expected none, got %0d",
                 $time, iteration_count_o);
      end else begin
        due = counts_due.pop_front();
        if (iteration_count_o !== due.count) begin
          errors++;
          $display("%0t: iteration count of pixel (%0d, %0d), expected %0d, got %0d",
                   $time, due.col, due.row, due.count, iteration_count_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    c_re     = jet_pkg::C_REAL_RST;
    c_im     = jet_pkg::C_IMAG_RST;
    x_org    = jet_pkg::ORIGIN_RST;
    y_org    = jet_pkg::ORIGIN_RST;
    x_inc    = jet_pkg::STEP_RST;
    y_inc    = jet_pkg::STEP_RST;
    esc_lim  = jet_pkg::LIMIT_RST;
    iter_cap = jet_pkg::MAX_ITER_RST;
    gap_pct  = 9;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    plan.push_back(pix_row(0, 0));
    plan.push_back(pix_row(255, 255));
    plan.push_back(pix_row(255, 0));
    plan.push_back(pix_row(0, 255));
    plan.push_back(cfg_row(jet_pkg::CFG_X_ORIGIN, 0));
    plan.push_back(cfg_row(jet_pkg::CFG_Y_ORIGIN, 0));
    plan.push_back(cfg_row(jet_pkg::CFG_X_STEP, 1 << 24));
    plan.push_back(cfg_row(jet_pkg::CFG_Y_STEP, 1 << 24));
    plan.push_back(pix_fixed(255, 0, 1));
    plan.push_back(pix_fixed(0, 255, 1));
    plan.push_back(pix_fixed(127, 127, 1));
    plan.push_back(pix_row(0, 0));
    plan.push_back(cfg_row(jet_pkg::CFG_MAX_ITER, 1));
    plan.push_back(pix_fixed(0, 0, 0));
    plan.push_back(pix_fixed(10, 0, 0));
    plan.push_back(pix_fixed(11, 0, 1));
    plan.push_back(cfg_row(jet_pkg::CFG_ESC_LIMIT, 0));
    plan.push_back(pix_fixed(0, 0, 0));
    plan.push_back(pix_fixed(1, 0, 1));
    plan.push_back(cfg_row(jet_pkg::CFG_ESC_LIMIT, 4096));
    plan.push_back(pix_fixed(64, 0, 0));
    plan.push_back(pix_fixed(64, 1, 1));
    plan.push_back(pix_fixed(255, 255, 1));
    // With c at zero and a zero iteration limit, the origin and the point 1.0 never escape.
    plan.push_back(cfg_row(jet_pkg::CFG_C_REAL, 0));
    plan.push_back(cfg_row(jet_pkg::CFG_C_IMAG, 0));
    plan.push_back(cfg_row(jet_pkg::CFG_MAX_ITER, 0));
    plan.push_back(pix_fixed(0, 0, 0));
    plan.push_back(pix_fixed(1, 0, 0));
    plan.push_back(pix_row(2, 0));
    plan.push_back(cfg_row(jet_pkg::CFG_C_REAL, -(1 << 26)));
    plan.push_back(cfg_row(jet_pkg::CFG_C_IMAG, 1 << 26));
    plan.push_back(cfg_row(jet_pkg::CFG_X_ORIGIN, -(1 << 27)));
    plan.push_back(cfg_row(jet_pkg::CFG_Y_ORIGIN, 1 << 27));
    plan.push_back(cfg_row(jet_pkg::CFG_X_STEP, 1 << 16));
    plan.push_back(cfg_row(jet_pkg::CFG_Y_STEP, 0));
    plan.push_back(cfg_row(jet_pkg::CFG_ESC_LIMIT, 4));
    plan.push_back(cfg_row(jet_pkg::CFG_MAX_ITER, 255));
    plan.push_back(pix_row(0, 0));
    plan.push_back(pix_row(255, 255));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_pixel(plan[i].col, plan[i].row, plan[i].fixed, plan[i].count);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      gap_pct = (p < 4) ? 9 : (p < 8) ? 79 : 0;
      case (p)
        3, 11:   mode = MODE_WIDE;
        6:       mode = MODE_DEEP;
        9:       mode = MODE_ZERO_CAP;
        default: mode = MODE_CLASSIC;
      endcase
      pick_settings(mode);
      n_items = (mode == MODE_ZERO_CAP) ? 20 : 110;
      repeat (n_items) begin
        send_pixel(jet_pkg::IDX_W'($urandom_range(255)), jet_pkg::IDX_W'($urandom_range(255)),
                   1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("summary: %0d pixel requests, %0d results checked, %0d register writes,",
             requests_sent, results_seen, writes_done);
    $display("summary: %0d random settings incl. wide, deep and zero-limit runs; %0d errors",
             RANDOM_PHASES, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
